@@ rtl/spmq_pkg.sv @@
package spmq_pkg;

	localparam int CLASS_COUNT = 4;
	localparam int CLASS_DEPTH = 16;

	localparam int HANDLE_W  = 32;
	localparam int PRIO_W    = 8;
	localparam int OCLASS_W  = 2;
	localparam int OCOUNT_W  = 7;
	localparam int TOTAL_W   = 32;

	localparam int CLS_W     = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
	localparam int PTR_W     = $clog2(CLASS_DEPTH);
	localparam int CNT_W     = $clog2(CLASS_DEPTH + 1);
	localparam int STORE_DEPTH = CLASS_COUNT * CLASS_DEPTH;
	localparam int ADDR_W    = $clog2(STORE_DEPTH);
	localparam int INF_W     = $clog2(STORE_DEPTH + 1);

	typedef enum logic {
		MODE_ENQ = 1'b0,
		MODE_DEQ = 1'b1
	} mode_t;

	// store access for one transfer
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	// flags of the result in flight
	typedef struct packed {
		logic                done;
		logic                accepted;
		logic                full_error;
		logic                out_valid;
		logic [OCLASS_W-1:0] out_class;
	} res_t;

	function automatic logic [ADDR_W-1:0] store_addr(
		input logic [CLS_W-1:0] cls,
		input logic [PTR_W-1:0] ptr
	);
		return ADDR_W'(cls) * ADDR_W'(CLASS_DEPTH) + ADDR_W'(ptr);
	endfunction

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(CLASS_DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

endpackage

@@ rtl/spmq_ram.sv @@
module spmq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/spmq_ctrl.sv @@
module spmq_ctrl
	import spmq_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic               mode,
	input  logic [PRIO_W-1:0]  priority_req,
	output mem_req_t           mem_req,
	output res_t               res,
	output logic [INF_W-1:0]   inflight,
	output logic [INF_W-1:0]   peak,
	output logic [TOTAL_W-1:0] handled
);

	logic [PTR_W-1:0] head_q [CLASS_COUNT];
	logic [PTR_W-1:0] tail_q [CLASS_COUNT];
	logic [CNT_W-1:0] cnt_q  [CLASS_COUNT];
	logic [INF_W-1:0]   inflight_q;
	logic [INF_W-1:0]   peak_q;
	logic [TOTAL_W-1:0] handled_q;
	res_t               res_q;

	logic [CLS_W-1:0] enq_cls;
	logic [CLS_W-1:0] deq_cls;
	logic             enq_full;
	logic             any_held;
	logic             enq_do;
	logic             deq_do;
	logic [INF_W-1:0] inflight_inc;

	// clamp requested class
	always_comb begin
		if (priority_req > PRIO_W'(CLASS_COUNT - 1)) begin
			enq_cls = CLS_W'(CLASS_COUNT - 1);
		end else begin
			enq_cls = CLS_W'(priority_req);
		end
	end

	// highest non-empty class wins
	always_comb begin
		deq_cls  = '0;
		any_held = 1'b0;
		for (int i = 0; i < CLASS_COUNT; i++) begin
			if (cnt_q[i] != '0) begin
				deq_cls  = CLS_W'(i);
				any_held = 1'b1;
			end
		end
	end

	assign enq_full     = (cnt_q[enq_cls] == CNT_W'(CLASS_DEPTH));
	assign enq_do       = take && (mode == MODE_ENQ) && !enq_full;
	assign deq_do       = take && (mode == MODE_DEQ) && any_held;
	assign inflight_inc = inflight_q + INF_W'(1);

	assign mem_req.we    = enq_do;
	assign mem_req.waddr = store_addr(enq_cls, tail_q[enq_cls]);
	assign mem_req.re    = deq_do;
	assign mem_req.raddr = store_addr(deq_cls, head_q[deq_cls]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CLASS_COUNT; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
			inflight_q <= '0;
			peak_q     <= '0;
			handled_q  <= '0;
			res_q      <= '0;
		end else begin
			res_q.done       <= take;
			res_q.accepted   <= enq_do;
			res_q.full_error <= take && (mode == MODE_ENQ) && enq_full;
			res_q.out_valid  <= deq_do;
			res_q.out_class  <= deq_do ? OCLASS_W'(deq_cls) : '0;
			if (enq_do) begin
				tail_q[enq_cls] <= ptr_next(tail_q[enq_cls]);
				cnt_q[enq_cls]  <= cnt_q[enq_cls] + CNT_W'(1);
				inflight_q      <= inflight_inc;
				if (inflight_inc > peak_q) begin
					peak_q <= inflight_inc;
				end
			end
			if (deq_do) begin
				head_q[deq_cls] <= ptr_next(head_q[deq_cls]);
				cnt_q[deq_cls]  <= cnt_q[deq_cls] - CNT_W'(1);
				inflight_q      <= inflight_q - INF_W'(1);
				handled_q       <= handled_q + TOTAL_W'(1);
			end
		end
	end

	assign res      = res_q;
	assign inflight = inflight_q;
	assign peak     = peak_q;
	assign handled  = handled_q;

endmodule

@@ rtl/strict_priority_multi_queue.sv @@
// Strict-priority multi-class task queue.
//
// Command channel: a transfer happens at a rising edge where start is high
// and busy is low. busy is always low here, so a command can be issued every
// cycle. mode selects enqueue (store handle in class min(priority_req, top
// class)) or dequeue (oldest handle of the highest non-empty class).
//
// Result channel: done pulses for one cycle, the cycle right after the
// command transfer, with all result fields valid in that cycle. Throughput is
// one command per cycle; the handle store is a single
// memory with one write and one registered read port, and any command only
// ever uses one of them. The receiver cannot stall: each result is shown for
// exactly one cycle and must be taken then.
//
// Reset (arst_n low) empties every class and clears the in-flight, peak and
// handled counters; store contents are left as is and are never read before
// being written.
module strict_priority_multi_queue
	import spmq_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                mode,
	input  logic [PRIO_W-1:0]   priority_req,
	input  logic [HANDLE_W-1:0] handle,
	output logic                done,
	output logic                accepted,
	output logic                full_error,
	output logic                out_valid,
	output logic [HANDLE_W-1:0] out_handle,
	output logic [OCLASS_W-1:0] out_class,
	output logic [OCOUNT_W-1:0] inflight_count,
	output logic [OCOUNT_W-1:0] peak_inflight,
	output logic [TOTAL_W-1:0]  total_handled
);

	mem_req_t           mem_req;
	res_t               res;
	logic [INF_W-1:0]   inflight;
	logic [INF_W-1:0]   peak;
	logic [HANDLE_W-1:0] rd_handle;

	// results are registered; never back-pressures
	assign busy = 1'b0;

	// pointers, fill levels, priority pick, counters
	spmq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (start && !busy),
		.mode         (mode),
		.priority_req (priority_req),
		.mem_req      (mem_req),
		.res          (res),
		.inflight     (inflight),
		.peak         (peak),
		.handled      (total_handled)
	);

	// handle store: enqueue writes at the transfer edge, dequeue reads at
	// the transfer edge, so read data lines up with the result cycle
	spmq_ram #(
		.WIDTH (HANDLE_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (handle),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (rd_handle)
	);

	assign done           = res.done;
	assign accepted       = res.accepted;
	assign full_error     = res.full_error;
	assign out_valid      = res.out_valid;
	assign out_class      = res.out_class;
	// zero unless a handle was actually removed
	assign out_handle     = res.out_valid ? rd_handle : '0;
	assign inflight_count = OCOUNT_W'(inflight);
	assign peak_inflight  = OCOUNT_W'(peak);

endmodule

@@ verif/spmq_checker.sv @@
module spmq_checker
	import spmq_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic                mode,
	input  logic [PRIO_W-1:0]   priority_req,
	input  logic [HANDLE_W-1:0] handle,
	input  logic                done,
	input  logic                accepted,
	input  logic                full_error,
	input  logic                out_valid,
	input  logic [HANDLE_W-1:0] out_handle,
	input  logic [OCLASS_W-1:0] out_class,
	input  logic [OCOUNT_W-1:0] inflight_count,
	input  logic [OCOUNT_W-1:0] peak_inflight,
	input  logic [TOTAL_W-1:0]  total_handled,
	output int unsigned         outstanding,
	output int unsigned         errors,
	output int unsigned         stored,
	output int unsigned         rejected,
	output int unsigned         popped,
	output int unsigned         empty_pops,
	output int unsigned         held_max
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic                accepted;
		logic                full_error;
		logic                out_valid;
		logic [HANDLE_W-1:0] out_handle;
		logic [OCLASS_W-1:0] out_class;
		logic [OCOUNT_W-1:0] inflight;
		logic [OCOUNT_W-1:0] peak;
		logic [TOTAL_W-1:0]  total;
	} sched_outcome_t;

	sched_outcome_t      pending_q[$];

	// shadow of the class queues
	logic [HANDLE_W-1:0] shadow_slot [CLASS_COUNT][CLASS_DEPTH];
	int unsigned         rd_ptr      [CLASS_COUNT];
	int unsigned         wr_ptr      [CLASS_COUNT];
	int unsigned         fill        [CLASS_COUNT];
	int unsigned         held;
	logic [TOTAL_W-1:0]  handled;
	int unsigned         err_cnt;
	int unsigned         n_stored, n_rejected, n_popped, n_empty;

	assign errors     = err_cnt;
	assign stored     = n_stored;
	assign rejected   = n_rejected;
	assign popped     = n_popped;
	assign empty_pops = n_empty;

	function automatic sched_outcome_t schedule_command(
		input logic                m,
		input logic [PRIO_W-1:0]   prio,
		input logic [HANDLE_W-1:0] h
	);
		sched_outcome_t o;
		int             cls;
		o = '0;
		if (m == MODE_ENQ) begin
			cls = (prio > CLASS_COUNT - 1) ? CLASS_COUNT - 1 : int'(prio);
			if (fill[cls] >= CLASS_DEPTH) begin
				o.full_error = 1'b1;
				n_rejected++;
			end else begin
				shadow_slot[cls][wr_ptr[cls]] = h;
				wr_ptr[cls] = (wr_ptr[cls] + 1) % CLASS_DEPTH;
				fill[cls]++;
				held++;
				if (held > held_max) begin
					held_max = held;
				end
				o.accepted = 1'b1;
				n_stored++;
			end
		end else begin
			cls = -1;
			for (int c = CLASS_COUNT - 1; c >= 0 && cls < 0; c--) begin
				if (fill[c] != 0) begin
					cls = c;
				end
			end
			if (cls < 0) begin
				n_empty++;
			end else begin
				o.out_valid  = 1'b1;
				o.out_handle = shadow_slot[cls][rd_ptr[cls]];
				o.out_class  = OCLASS_W'(cls);
				rd_ptr[cls] = (rd_ptr[cls] + 1) % CLASS_DEPTH;
				fill[cls]--;
				held--;
				handled++;
				n_popped++;
			end
		end
		o.inflight = OCOUNT_W'(held);
		o.peak     = OCOUNT_W'(held_max);
		o.total    = handled;
		return o;
	endfunction

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			err_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		sched_outcome_t w;
		if (!arst_n) begin
			for (int c = 0; c < CLASS_COUNT; c++) begin
				rd_ptr[c] = 0;
				wr_ptr[c] = 0;
				fill[c]   = 0;
			end
			held     = 0;
			held_max = 0;
			handled  = '0;
			pending_q.delete();
			outstanding <= 0;
		end else begin
			// predict first so a result in the same cycle as its command would still line up
			if (start && !busy) begin
				pending_q.push_back(schedule_command(mode, priority_req, handle));
			end
			if (done) begin
				if (pending_q.size() == 0) begin
					$error("result transfer with no command outstanding");
					err_cnt++;
				end else begin
					w = pending_q.pop_front();
					check_field("accepted",       64'(w.accepted),   64'(accepted));
					check_field("full_error",     64'(w.full_error), 64'(full_error));
					check_field("out_valid",      64'(w.out_valid),  64'(out_valid));
					check_field("out_handle",     64'(w.out_handle), 64'(out_handle));
					check_field("out_class",      64'(w.out_class),  64'(out_class));
					check_field("inflight_count", 64'(w.inflight),   64'(inflight_count));
					check_field("peak_inflight",  64'(w.peak),       64'(peak_inflight));
					check_field("total_handled",  64'(w.total),      64'(total_handled));
				end
			end
			outstanding <= pending_q.size();
		end
	end

	initial begin
		err_cnt    = 0;
		n_stored   = 0;
		n_rejected = 0;
		n_popped   = 0;
		n_empty    = 0;
	end

endmodule

@@ verif/tb_strict_priority_multi_queue.sv @@
module tb_strict_priority_multi_queue;
	import spmq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// random commands after the directed opening
	localparam int RANDOM_ITEMS  = 1525;
	// cycles without any transfer before the run is declared hung
	localparam int STALL_LIMIT   = 1000;
	// spare cycles to catch stray results
	localparam int SETTLE_CYCLES = 4;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                start        = 1'b0;
	logic                mode         = MODE_ENQ;
	logic [PRIO_W-1:0]   priority_req = '0;
	logic [HANDLE_W-1:0] handle       = '0;

	logic                busy;
	logic                done;
	logic                accepted;
	logic                full_error;
	logic                out_valid;
	logic [HANDLE_W-1:0] out_handle;
	logic [OCLASS_W-1:0] out_class;
	logic [OCOUNT_W-1:0] inflight_count;
	logic [OCOUNT_W-1:0] peak_inflight;
	logic [TOTAL_W-1:0]  total_handled;

	int unsigned outstanding, errors, stored, rejected, popped, empty_pops, held_max;
	int unsigned stall_cycles = 0;

	always #10 clk = ~clk;

	strict_priority_multi_queue i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.mode           (mode),
		.priority_req   (priority_req),
		.handle         (handle),
		.done           (done),
		.accepted       (accepted),
		.full_error     (full_error),
		.out_valid      (out_valid),
		.out_handle     (out_handle),
		.out_class      (out_class),
		.inflight_count (inflight_count),
		.peak_inflight  (peak_inflight),
		.total_handled  (total_handled)
	);

	// Scoreboard sits beside the DUT on the same wires: predicts each
	// command transfer and checks the matching result transfer.
	spmq_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.mode           (mode),
		.priority_req   (priority_req),
		.handle         (handle),
		.done           (done),
		.accepted       (accepted),
		.full_error     (full_error),
		.out_valid      (out_valid),
		.out_handle     (out_handle),
		.out_class      (out_class),
		.inflight_count (inflight_count),
		.peak_inflight  (peak_inflight),
		.total_handled  (total_handled),
		.outstanding    (outstanding),
		.errors         (errors),
		.stored         (stored),
		.rejected       (rejected),
		.popped         (popped),
		.empty_pops     (empty_pops),
		.held_max       (held_max)
	);

	// One command transfer. Optional random idle cycles first (~22% of
	// cycles); while idle the payload wiggles so the DUT must ignore it.
	// start stays high between back-to-back commands, never dropped and
	// re-raised in the same step.
	task automatic issue(
		input logic                m,
		input logic [PRIO_W-1:0]   prio,
		input logic [HANDLE_W-1:0] h,
		input bit                  may_idle
	);
		while (may_idle && $urandom_range(99) < 22) begin
			start        <= 1'b0;
			mode         <= 1'($urandom_range(1));
			priority_req <= PRIO_W'($urandom_range(255));
			handle       <= $urandom;
			@(posedge clk);
		end
		start        <= 1'b1;
		mode         <= m;
		priority_req <= prio;
		handle       <= h;
		do @(posedge clk); while (busy);
	endtask

	// Watchdog: any cycle with a command or result transfer resets it.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	initial begin
		mode_t            m;
		logic [PRIO_W-1:0] p;
		int               seg_left;
		int               enq_pct;
		int               hot_cls;
		int               r;
		bit               quiet;

		seg_left = 0;
		enq_pct  = 50;
		hot_cls  = -1;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed opening ---
		// dequeue with nothing stored; handle is don't-care on dequeue
		issue(MODE_DEQ, '0, '1, 1'b0);
		// one handle per class, handle extremes
		issue(MODE_ENQ, PRIO_W'(0), '0, 1'b0);
		issue(MODE_ENQ, PRIO_W'(1), '1, 1'b0);
		issue(MODE_ENQ, PRIO_W'(2), 32'hA5A5_5A5A, 1'b0);
		// out-of-range priorities clamp to the top class
		issue(MODE_ENQ, 8'hFF, 32'h8000_0001, 1'b0);
		issue(MODE_ENQ, PRIO_W'(CLASS_COUNT), 32'h0000_0001, 1'b0);
		// fill the top class to its depth, then overflow it
		for (int i = 0; i < CLASS_DEPTH - 2; i++) begin
			issue(MODE_ENQ, PRIO_W'($urandom_range(255, CLASS_COUNT - 1)), $urandom, 1'b0);
		end
		issue(MODE_ENQ, 8'h80, 32'hDEAD_BEEF, 1'b0);
		// drain a few from the top: oldest first
		repeat (4) issue(MODE_DEQ, '0, $urandom, 1'b0);

		// --- random part ---
		// Segments are fill-heavy, balanced or drain-heavy, picked at random;
		// half of them hammer one class so it fills up and its pointers wrap.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (seg_left == 0) begin
				seg_left = $urandom_range(80, 10);
				case ($urandom_range(2))
					0: enq_pct = 15;
					1: enq_pct = 50;
					default: enq_pct = 85;
				endcase
				hot_cls = ($urandom_range(1) != 0) ? int'($urandom_range(CLASS_COUNT - 1)) : -1;
			end
			seg_left--;

			// hold off until every outstanding result has come back
			if (n == 400 || n == 1200) begin
				start <= 1'b0;
				do @(posedge clk); while (outstanding != 0);
			end

			// long back-to-back stretch with no idle cycles
			quiet = (n >= 700 && n < 1000);

			m = ($urandom_range(99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
			r = $urandom_range(99);
			if (hot_cls >= 0 && r < 60) begin
				p = PRIO_W'(hot_cls);
			end else if (r < 80) begin
				p = PRIO_W'($urandom_range(CLASS_COUNT - 1));
			end else begin
				p = PRIO_W'($urandom_range(255));
			end
			issue(m, p, $urandom, !quiet);
		end

		// wait for the last result, then a few more cycles for strays
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Ran %0d commands: %0d handles stored, %0d dropped on a full class,",
			stored + rejected + popped + empty_pops, stored, rejected);
		$display("%0d handles dequeued, %0d dequeues on empty storage, peak occupancy %0d.",
			popped, empty_pops, held_max);
		if (errors == 0 && outstanding == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/spmq_pkg.sv
rtl/spmq_ram.sv
rtl/spmq_ctrl.sv
rtl/strict_priority_multi_queue.sv
verif/spmq_checker.sv
verif/tb_strict_priority_multi_queue.sv
